FILE: design/pps_pkg.sv
// Shared types and constants of the preemptive priority scheduler
package pps_pkg;

  localparam int CMD_W  = 2;
  localparam int SLOT_W = 6;
  localparam int ID_W   = 8;
  localparam int TIME_W = 16;
  localparam int PRIO_W = 8;
  localparam int CNT_W  = 7;
  localparam int SUM_W  = 22;

  // Command codes of an input item
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;
  localparam logic [SUM_W-1:0]  SUM_MAX  = 22'h3F_FFFF;
  localparam logic [CNT_W-1:0]  COUNT_RESET = 7'd1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] arrival;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] burst;
  } pps_in_t;

  typedef struct packed {
    logic [ID_W-1:0]   running_id;
    logic              cpu_idle;
    logic              switched;
    logic              first_run;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
    logic [TIME_W-1:0] now_time;
    logic [SUM_W-1:0]  total_turnaround;
    logic [SUM_W-1:0]  total_waiting;
  } pps_out_t;

  // One task slot as held in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] arrival;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] burst;
  } pps_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_FIGURE,
    ST_COMMIT
  } pps_state_t;

endpackage

FILE: design/pps_ram.sv
// Generic single-write, single-read RAM with registered read data
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/preemptive_priority_scheduler_top.sv
// Top level of the preemptive priority scheduler: slot memories, scan and commit
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+--------------------------
//   in_      | input     | in_valid / in_ready   | pps_in_t  (cmd, slot, ...)
//   out_     | output    | out_valid / out_ready | pps_out_t (one per item)
//   cfg_     | input     | cfg_valid / cfg_ready | task_count, 7 bits
//
// Each item passes through accept, a scan that reads one slot per cycle from the
// slot memories (n reads, n = min(task_count, MAX_TASKS), then the registered read
// data and a closing step), the arithmetic states CALC and FIGURE, and a commit
// into the result register. Reset is synchronous and needs no clearing pass;
// per-slot done and modified flags sit in flip-flops. A stalled result holds the
// commit, and a new item is taken once the previous one has reached the result
// register.
module preemptive_priority_scheduler_top #(
  parameter int MAX_TASKS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pps_pkg::pps_in_t        in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output pps_pkg::pps_out_t       out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [pps_pkg::CNT_W-1:0] cfg_data
);

  localparam int IW    = $clog2(MAX_TASKS);
  localparam int CW    = IW + 1;
  localparam int NW    = IW + pps_pkg::CNT_W + 1;
  localparam int REC_W = $bits(pps_pkg::pps_rec_t);
  localparam int TW    = pps_pkg::TIME_W;
  localparam int SW    = pps_pkg::SUM_W;
  localparam int SLOT_PAD = pps_pkg::SLOT_W;

  pps_pkg::pps_state_t state_r, state_nxt;

  pps_pkg::pps_in_t    item_r;
  logic [pps_pkg::CNT_W-1:0] task_count_r;
  logic [TW-1:0]       time_r;
  logic [SW-1:0]       sum_t_r;
  logic [SW-1:0]       sum_w_r;
  logic [pps_pkg::ID_W-1:0] last_id_r;
  logic                last_valid_r;
  logic [MAX_TASKS-1:0] done_r;
  logic [MAX_TASKS-1:0] dirty_r;

  logic [CW-1:0]       rd_idx_r;
  logic                pv_r;
  logic [IW-1:0]       pslot_r;
  logic [CW-1:0]       nd_r;

  logic                found_r;
  logic [IW-1:0]       bslot_r;
  logic [pps_pkg::PRIO_W-1:0] bprio_r;
  logic [TW-1:0]       barr_r;
  logic [pps_pkg::ID_W-1:0] bid_r;
  logic [TW-1:0]       bburst_r;
  logic [TW-1:0]       brem_r;

  logic [TW-1:0]       tnew_r;
  logic [TW-1:0]       ta_r;
  logic [TW-1:0]       wt_r;
  logic [TW-1:0]       rem_new_r;
  logic                fin_r;

  logic                out_valid_r;
  pps_pkg::pps_out_t   out_r;

  // Control decode
  logic                in_fire;
  logic                is_tick;
  logic                scan_issue;
  logic                scan_end;
  logic                out_free;
  logic                commit;
  logic [CW-1:0]       n_slots;
  logic [NW-1:0]       tc_ext;
  logic [IW+SLOT_PAD-1:0] slot_ext;
  logic                slot_ok;
  logic [IW-1:0]       waddr;
  logic                rec_we;
  logic                rem_we;

  // Memory data
  pps_pkg::pps_rec_t   wr_rec;
  pps_pkg::pps_rec_t   rd_rec;
  logic [REC_W-1:0]    rec_rdata;
  logic [TW-1:0]       rem_rdata;

  // Scan compare
  logic                cur_done;
  logic [TW-1:0]       cur_rem;
  logic                eligible;
  logic                better;

  // Commit arithmetic
  logic [SW:0]         sum_t_add;
  logic [SW:0]         sum_w_add;
  logic [SW-1:0]       sum_t_new;
  logic [SW-1:0]       sum_w_new;
  logic                tick_found;
  pps_pkg::pps_out_t   res;
  logic [TW-1:0]       tnew;

  // Active slot count, capped at the memory depth
  assign tc_ext  = NW'(task_count_r);
  assign n_slots = (tc_ext > NW'(MAX_TASKS)) ? CW'(MAX_TASKS) : tc_ext[CW-1:0];

  assign in_fire  = in_valid && in_ready;
  assign is_tick  = (item_r.cmd == pps_pkg::CMD_TICK);
  assign out_free = !out_valid_r || out_ready;

  assign scan_issue = (state_r == pps_pkg::ST_SCAN) && (rd_idx_r < n_slots);
  assign scan_end   = (state_r == pps_pkg::ST_SCAN) && !scan_issue && !pv_r;
  assign commit     = (state_r == pps_pkg::ST_COMMIT) && out_free;

  // Load address, in range only below the memory depth
  assign slot_ext = {IW'(0), in_data.slot};
  assign slot_ok  = slot_ext < (IW + SLOT_PAD)'(MAX_TASKS);
  assign waddr    = slot_ext[IW-1:0];

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pps_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = pps_pkg::ST_SCAN;
      end
      pps_pkg::ST_SCAN: begin
        if (scan_end) state_nxt = pps_pkg::ST_CALC;
      end
      pps_pkg::ST_CALC:   state_nxt = pps_pkg::ST_FIGURE;
      pps_pkg::ST_FIGURE: state_nxt = pps_pkg::ST_COMMIT;
      pps_pkg::ST_COMMIT: begin
        if (out_free) state_nxt = pps_pkg::ST_IDLE;
      end
      default: state_nxt = pps_pkg::ST_IDLE;
    endcase
  end

  // State outputs: handshake and memory writes
  always_comb begin
    in_ready = 1'b0;
    rec_we   = 1'b0;
    rem_we   = 1'b0;
    case (state_r)
      pps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        rec_we   = in_valid && (in_data.cmd == pps_pkg::CMD_LOAD) && slot_ok;
      end
      pps_pkg::ST_COMMIT: begin
        rem_we = out_free && is_tick && found_r;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Slot memory: identifier, arrival, priority, burst
  always_comb begin
    wr_rec.task_id = in_data.task_id;
    wr_rec.arrival = in_data.arrival;
    wr_rec.prio    = in_data.prio;
    wr_rec.burst   = in_data.burst;
  end

  pps_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_TASKS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (waddr),
    .wdata (wr_rec),
    .raddr (rd_idx_r[IW-1:0]),
    .rdata (rec_rdata)
  );

  // Remaining-work memory; an entry not modified since load or restart reads as burst
  pps_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_TASKS)
  ) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (bslot_r),
    .wdata (rem_new_r),
    .raddr (rd_idx_r[IW-1:0]),
    .rdata (rem_rdata)
  );

  // Scan compare on the slot returned by the memories
  always_comb begin
    rd_rec   = pps_pkg::pps_rec_t'(rec_rdata);
    cur_done = done_r[pslot_r];
    cur_rem  = dirty_r[pslot_r] ? rem_rdata : rd_rec.burst;
    eligible = !cur_done && (rd_rec.arrival <= time_r);
    better   = !found_r || (rd_rec.prio < bprio_r) ||
               ((rd_rec.prio == bprio_r) && (rd_rec.arrival < barr_r));
  end

  // Saturating totals and the result item
  always_comb begin
    tnew       = (time_r == pps_pkg::TIME_MAX) ? time_r : time_r + TW'(1);
    sum_t_add  = {1'b0, sum_t_r} + (SW + 1)'(ta_r);
    sum_w_add  = {1'b0, sum_w_r} + (SW + 1)'(wt_r);
    sum_t_new  = sum_t_add[SW] ? pps_pkg::SUM_MAX : sum_t_add[SW-1:0];
    sum_w_new  = sum_w_add[SW] ? pps_pkg::SUM_MAX : sum_w_add[SW-1:0];
    tick_found = is_tick && found_r;

    res.running_id       = tick_found ? bid_r : '0;
    res.cpu_idle         = !tick_found;
    res.switched         = tick_found && (!last_valid_r || (last_id_r != bid_r));
    res.first_run        = tick_found && (brem_r == bburst_r);
    res.finished         = fin_r;
    res.finish_time      = fin_r ? tnew_r : '0;
    res.turnaround       = fin_r ? ta_r : '0;
    res.waiting          = fin_r ? wt_r : '0;
    res.all_done         = (nd_r == CW'(0)) || ((nd_r == CW'(1)) && fin_r);
    res.now_time         = is_tick ? tnew_r : time_r;
    res.total_turnaround = fin_r ? sum_t_new : sum_t_r;
    res.total_waiting    = fin_r ? sum_w_new : sum_w_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pps_pkg::ST_IDLE;
      task_count_r <= pps_pkg::COUNT_RESET;
      time_r       <= '0;
      sum_t_r      <= '0;
      sum_w_r      <= '0;
      last_id_r    <= '0;
      last_valid_r <= 1'b0;
      done_r       <= '0;
      dirty_r      <= '0;
      rd_idx_r     <= '0;
      pv_r         <= 1'b0;
      found_r      <= 1'b0;
      nd_r         <= '0;
      fin_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Take the register write
      if (cfg_valid && cfg_ready) begin
        task_count_r <= cfg_data;
      end

      // Accept an item and apply load or restart
      if (in_fire) begin
        rd_idx_r <= '0;
        pv_r     <= 1'b0;
        found_r  <= 1'b0;
        nd_r     <= '0;
        fin_r    <= 1'b0;
        if (in_data.cmd == pps_pkg::CMD_RESTART) begin
          time_r       <= '0;
          sum_t_r      <= '0;
          sum_w_r      <= '0;
          last_id_r    <= '0;
          last_valid_r <= 1'b0;
          done_r       <= '0;
          dirty_r      <= '0;
        end else if ((in_data.cmd == pps_pkg::CMD_LOAD) && slot_ok) begin
          done_r[waddr]  <= 1'b0;
          dirty_r[waddr] <= 1'b0;
        end
      end

      // Advance the scan one slot per cycle
      if (state_r == pps_pkg::ST_SCAN) begin
        pv_r <= scan_issue;
        if (scan_issue) begin
          rd_idx_r <= rd_idx_r + CW'(1);
        end
        if (pv_r) begin
          if (!cur_done) nd_r <= nd_r + CW'(1);
          if (eligible && better) found_r <= 1'b1;
        end
      end

      // Decide completion of the chosen task
      if (state_r == pps_pkg::ST_CALC) begin
        fin_r <= is_tick && found_r && (brem_r <= TW'(1));
      end

      // Commit state and hand the result to the output register
      if (commit) begin
        if (is_tick) begin
          time_r <= tnew_r;
          if (found_r) begin
            last_id_r        <= bid_r;
            last_valid_r     <= 1'b1;
            dirty_r[bslot_r] <= 1'b1;
          end
          if (fin_r) begin
            done_r[bslot_r] <= 1'b1;
            sum_t_r         <= sum_t_new;
            sum_w_r         <= sum_w_new;
          end
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end

    // Hold the best candidate seen so far
    if ((state_r == pps_pkg::ST_SCAN) && pv_r && eligible && better) begin
      bslot_r  <= pslot_r;
      bprio_r  <= rd_rec.prio;
      barr_r   <= rd_rec.arrival;
      bid_r    <= rd_rec.task_id;
      bburst_r <= rd_rec.burst;
      brem_r   <= cur_rem;
    end
    if (state_r == pps_pkg::ST_SCAN) begin
      pslot_r <= rd_idx_r[IW-1:0];
    end

    // New time, remaining work and turnaround
    if (state_r == pps_pkg::ST_CALC) begin
      tnew_r    <= tnew;
      ta_r      <= tnew - barr_r;
      rem_new_r <= (brem_r <= TW'(1)) ? '0 : brem_r - TW'(1);
    end

    // Waiting time, floored at zero
    if (state_r == pps_pkg::ST_FIGURE) begin
      wt_r <= (ta_r > bburst_r) ? ta_r - bburst_r : '0;
    end

    if (commit) begin
      out_r <= res;
    end
  end

endmodule

FILE: test/pps_checker.sv
// Scoreboard for the priority scheduler: watches all three channels, predicts and compares
module pps_checker
  import pps_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  pps_in_t          in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  pps_out_t         out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTS = 40;

  // Scheduler state as the block should hold it
  logic [ID_W-1:0]   id_mem    [SLOTS];
  logic [TIME_W-1:0] arr_mem   [SLOTS];
  logic [PRIO_W-1:0] prio_mem  [SLOTS];
  logic [TIME_W-1:0] burst_mem [SLOTS];
  logic [TIME_W-1:0] left_mem  [SLOTS];
  logic              done_mem  [SLOTS];
  logic [TIME_W-1:0] clock_now;
  logic [ID_W-1:0]   prev_id;
  logic              prev_valid;
  logic [SUM_W-1:0]  sum_ta;
  logic [SUM_W-1:0]  sum_wt;
  logic [CNT_W-1:0]  slot_count;

  pps_out_t expected_q[$];
  int       results_seen;

  task automatic report_error(input string msg);
    // keep the log short when the block is badly broken
    if (errors < MAX_PRINTS)
      $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    errors++;
  endtask

  function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] acc, input int add);
    int s;
    s = int'(acc) + add;
    return (s > int'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic void clear_run();
    for (int i = 0; i < SLOTS; i++) done_mem[i] = 1'b0;
    clock_now  = '0;
    prev_id    = '0;
    prev_valid = 1'b0;
    sum_ta     = '0;
    sum_wt     = '0;
  endfunction

  // Apply one item to the state and return the result it should produce
  function automatic pps_out_t schedule_step(input pps_in_t it);
    pps_out_t r;
    int       n;
    int       best;
    bit       found;
    bit       fin;
    int       ta;
    int       wt;
    r = '0;
    r.cpu_idle = 1'b1;
    n = (int'(slot_count) > SLOTS) ? SLOTS : int'(slot_count);
    fin = 1'b0;
    case (it.cmd)
      CMD_LOAD: begin
        if (int'(it.slot) < SLOTS) begin
          id_mem[it.slot]    = it.task_id;
          arr_mem[it.slot]   = it.arrival;
          prio_mem[it.slot]  = it.prio;
          burst_mem[it.slot] = it.burst;
          left_mem[it.slot]  = it.burst;
          done_mem[it.slot]  = 1'b0;
        end
      end
      CMD_RESTART: begin
        clear_run();
        for (int i = 0; i < SLOTS; i++) left_mem[i] = burst_mem[i];
      end
      CMD_TICK: begin
        found = 1'b0;
        best  = 0;
        // pick lowest priority value, then earliest arrival, then lowest slot
        for (int i = 0; i < n; i++) begin
          if (!done_mem[i] && arr_mem[i] <= clock_now) begin
            if (!found || prio_mem[i] < prio_mem[best] ||
                (prio_mem[i] == prio_mem[best] && arr_mem[i] < arr_mem[best])) begin
              best  = i;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          r.cpu_idle   = 1'b0;
          r.running_id = id_mem[best];
          r.first_run  = (left_mem[best] == burst_mem[best]);
          r.switched   = !prev_valid || (prev_id != id_mem[best]);
          prev_id      = id_mem[best];
          prev_valid   = 1'b1;
          if (left_mem[best] <= 1) begin
            left_mem[best] = '0;
            fin = 1'b1;
          end else begin
            left_mem[best] = left_mem[best] - 1'b1;
          end
        end
        if (clock_now != TIME_MAX) clock_now = clock_now + 1'b1;
        if (fin) begin
          ta = int'(clock_now) - int'(arr_mem[best]);
          wt = (ta > int'(burst_mem[best])) ? ta - int'(burst_mem[best]) : 0;
          r.finished    = 1'b1;
          r.finish_time = clock_now;
          r.turnaround  = ta[TIME_W-1:0];
          r.waiting     = wt[TIME_W-1:0];
          sum_ta        = sum_sat(sum_ta, ta);
          sum_wt        = sum_sat(sum_wt, wt);
          done_mem[best] = 1'b1;
        end
      end
      default: ;
    endcase
    r.all_done = 1'b1;
    for (int i = 0; i < n; i++)
      if (!done_mem[i]) r.all_done = 1'b0;
    r.now_time         = clock_now;
    r.total_turnaround = sum_ta;
    r.total_waiting    = sum_wt;
    return r;
  endfunction

  task automatic check_result(input pps_out_t got, input pps_out_t want);
    if (got.running_id !== want.running_id)
      report_error($sformatf("running_id %0h, want %0h", got.running_id, want.running_id));
    if (got.cpu_idle !== want.cpu_idle)
      report_error($sformatf("cpu_idle %0b, want %0b", got.cpu_idle, want.cpu_idle));
    if (got.switched !== want.switched)
      report_error($sformatf("switched %0b, want %0b", got.switched, want.switched));
    if (got.first_run !== want.first_run)
      report_error($sformatf("first_run %0b, want %0b", got.first_run, want.first_run));
    if (got.finished !== want.finished)
      report_error($sformatf("finished %0b, want %0b", got.finished, want.finished));
    if (got.finish_time !== want.finish_time)
      report_error($sformatf("finish_time %0d, want %0d", got.finish_time, want.finish_time));
    if (got.turnaround !== want.turnaround)
      report_error($sformatf("turnaround %0d, want %0d", got.turnaround, want.turnaround));
    if (got.waiting !== want.waiting)
      report_error($sformatf("waiting %0d, want %0d", got.waiting, want.waiting));
    if (got.all_done !== want.all_done)
      report_error($sformatf("all_done %0b, want %0b", got.all_done, want.all_done));
    if (got.now_time !== want.now_time)
      report_error($sformatf("now_time %0d, want %0d", got.now_time, want.now_time));
    if (got.total_turnaround !== want.total_turnaround)
      report_error($sformatf("total_turnaround %0d, want %0d",
                             got.total_turnaround, want.total_turnaround));
    if (got.total_waiting !== want.total_waiting)
      report_error($sformatf("total_waiting %0d, want %0d",
                             got.total_waiting, want.total_waiting));
  endtask

  // Sample all handshakes at the rising edge; results first, since they belong to older items
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        id_mem[i]    = '0;
        arr_mem[i]   = '0;
        prio_mem[i]  = '0;
        burst_mem[i] = '0;
        left_mem[i]  = '0;
      end
      clear_run();
      slot_count   = COUNT_RESET;
      expected_q.delete();
      results_seen = 0;
      errors       = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0)
          report_error("result with no item waiting");
        else
          check_result(out_data, expected_q.pop_front());
        results_seen++;
      end
      if (cfg_valid && cfg_ready) slot_count = cfg_data;
      if (in_valid && in_ready) expected_q.push_back(schedule_step(in_data));
    end
    pending = expected_q.size();
  end

endmodule

FILE: test/tb.sv
// Stimulus and verdict for the preemptive priority scheduler
module tb;
  import pps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 64;
  localparam int RANDOM_ITEMS = 540;
  localparam int LIMIT        = 600_000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  pps_in_t          in_data;
  logic             out_valid;
  logic             out_ready = 1'b0;
  pps_out_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  int errors;
  int pending;
  int cycles     = 0;
  int stall_left = 0;
  int counted    = 0;
  bit no_gaps    = 1'b0;

  preemptive_priority_scheduler_top #(.MAX_TASKS(SLOTS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  pps_checker #(.SLOTS(SLOTS)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result channel at random
  always @(negedge clk) begin
    if (no_gaps || !rst_n) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) stall_left <= pick_gap();
    end
  end

  function automatic pps_in_t random_fields();
    pps_in_t it;
    it.cmd     = CMD_TICK;
    it.slot    = SLOT_W'($urandom());
    it.task_id = ID_W'($urandom());
    it.arrival = TIME_W'($urandom());
    it.prio    = PRIO_W'($urandom());
    it.burst   = TIME_W'($urandom());
    return it;
  endfunction

  // Present one item after an optional gap and hold it until accepted
  task automatic send_item(input pps_in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.cmd != CMD_UNUSED) counted++;
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] cmd);
    pps_in_t it;
    it = random_fields();
    it.cmd = cmd;
    send_item(it);
  endtask

  task automatic send_load(input int slot, input int id, input int arr, input int prio,
                           input int burst);
    pps_in_t it;
    it = random_fields();
    it.cmd     = CMD_LOAD;
    it.slot    = slot[SLOT_W-1:0];
    it.task_id = id[ID_W-1:0];
    it.arrival = arr[TIME_W-1:0];
    it.prio    = prio[PRIO_W-1:0];
    it.burst   = burst[TIME_W-1:0];
    send_item(it);
  endtask

  // Load a slot with short work, or with fully random fields now and then
  task automatic send_load_random(input int slot, input bit wide);
    pps_in_t it;
    it = random_fields();
    it.cmd  = CMD_LOAD;
    it.slot = slot[SLOT_W-1:0];
    if (!wide && $urandom_range(0, 7) != 0) begin
      it.arrival = TIME_W'($urandom_range(0, 12));
      it.burst   = TIME_W'($urandom_range(0, 6));
      if ($urandom_range(0, 1) != 0) it.prio = PRIO_W'($urandom_range(0, 3));
    end
    send_item(it);
  endtask

  // Hold the sender until every result is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_count(input int value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value[CNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(65, 127);
    if (r < 4) return $urandom_range(9, 64);
    return $urandom_range(1, 8);
  endfunction

  initial begin
    int k;
    int ticks;
    int base;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill every slot so that any count and any restart reads loaded slots
    for (int s = 0; s < SLOTS; s++)
      send_load(s, $urandom(), $urandom_range(0, 30), $urandom(), $urandom_range(1, 4));

    // Directed: zero burst, extreme fields, arrival and slot ties, id zero running
    write_count(5);
    send_load(0, 8'hFF, 0, 8'h00, 0);
    send_load(1, 8'h00, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_load(2, 8'h55, 1, 3, 2);
    send_load(3, 8'hAA, 0, 3, 1);
    send_load(4, 8'h33, 1, 3, 2);
    repeat (7) send_cmd(CMD_TICK);
    send_cmd(CMD_UNUSED);
    send_cmd(CMD_RESTART);
    send_cmd(CMD_TICK);
    send_load(1, 8'h00, 0, 8'h00, 2);
    send_cmd(CMD_TICK);
    send_cmd(CMD_TICK);
    write_count(0);
    send_cmd(CMD_TICK);
    write_count(127);
    send_cmd(CMD_TICK);
    write_count(64);
    send_cmd(CMD_TICK);

    // Random episodes: set a count, load short tasks, tick through with some noise
    base = counted;
    while (counted - base < RANDOM_ITEMS) begin
      k = pick_count();
      no_gaps = ($urandom_range(0, 4) == 0);
      write_count(k);
      if ($urandom_range(0, 4) != 0) send_cmd(CMD_RESTART);
      if (k >= 1 && k <= 8) begin
        for (int s = 0; s < k; s++) send_load_random(s, 1'b0);
        ticks = $urandom_range(15, 50);
      end else begin
        repeat ($urandom_range(1, 8)) send_load_random($urandom_range(0, SLOTS - 1), 1'b0);
        ticks = $urandom_range(20, 60);
      end
      repeat (ticks) begin
        if ($urandom_range(0, 39) == 0) wait_drained();
        case ($urandom_range(0, 29))
          0:       send_load_random($urandom_range(0, SLOTS - 1), 1'b1);
          1:       send_cmd(CMD_UNUSED);
          2:       send_cmd(CMD_RESTART);
          default: send_cmd(CMD_TICK);
        endcase
      end
    end
    no_gaps = 1'b0;

    // Drain, then let the pipeline settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
